// ===== hdl/osw_pkg.sv =====
// Package for the optical switch table: request word, table entry, status codes
// and the command group between controller and datapath. Depends on nothing.
`default_nettype none
package osw_pkg;

   typedef enum logic [1:0] {
      MODE_ROUTE  = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_VERIFY = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_SWITCHED  = 4'd0,
      ST_DISAGG    = 4'd1,
      ST_DROPPED   = 4'd2,
      ST_INSERTED  = 4'd3,
      ST_CONFLICT  = 4'd4,
      ST_FULL      = 4'd5,
      ST_REMOVED   = 4'd6,
      ST_NOT_FOUND = 4'd7,
      ST_VERIFIED  = 4'd8,
      ST_UNKNOWN   = 4'd9
   } status_type;

   typedef struct packed {
      logic [3:0]         in_port;
      logic [5:0]         in_lambda;
      logic signed [4:0]  out_port;
      logic signed [6:0]  out_lambda;
      logic               is_buffer;
      logic               to_buffer;
      logic               is_disagg;
      logic [31:0]        start_time;
      logic [31:0]        stop_time;
      logic [15:0]        entry_id;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hdl/osw_ctrl.sv =====
// Controller of the optical switch table: a two-state sequencer that captures
// a request word and commits it in the following cycle. Depends on osw_pkg.
`default_nettype none
module osw_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   output logic                busy,
   output logic                rsp_strobe,
   output osw_pkg::cmd_type    cmd
);
   import osw_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EVAL = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.commit;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("Result word shown while busy.");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("Accepted word did not start work.");
   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_strobe)) else $error("Work did not end in one result.");

endmodule
`default_nettype wire

// ===== hdl/osw_datapath.sv =====
// Datapath of the optical switch table: entry registers, parallel match and
// slot check, shifting removal and running counters. Depends on osw_pkg.
`default_nettype none
module osw_datapath #(
   parameter int TABLE_DEPTH = 32,
   parameter int TIME_BITS   = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire osw_pkg::cmd_type   cmd,
   input  wire logic               csr_we,
   input  wire logic [15:0]        csr_wdata,
   input  wire logic [1:0]         req_mode,
   input  wire osw_pkg::entry_type req_entry,
   output logic [3:0]              rsp_status,
   output logic signed [4:0]       rsp_route_port,
   output logic signed [6:0]       rsp_route_lambda,
   output logic                    rsp_converted,
   output logic [5:0]              rsp_elec_total,
   output logic [5:0]              rsp_elec_disagg,
   output logic [5:0]              rsp_elec_buffer
);
   import osw_pkg::*;

   localparam int D  = TABLE_DEPTH;
   localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [31:0] TMASK = 32'hFFFF_FFFF >> (32 - TW);

   entry_type   tbl_ff [D];
   entry_type   tbl_in [D];
   logic [D-1:0] valid_ff, valid_in;
   entry_type   req_ff;
   entry_type   req_masked;
   logic [1:0]  mode_ff;
   logic [15:0] guard_ff;
   logic [CW-1:0] cnt_d_ff, cnt_d_in, cnt_b_ff, cnt_b_in;

   logic [D-1:0] route_hit, id_hit, clash_hit, route_first, id_first, id_ge, wr_slot;
   entry_type    route_sel, id_sel;
   logic         clash, full;
   logic signed [33:0] ns, np, gs;
   logic signed [33:0] s0 [D];
   logic signed [33:0] s1 [D];
   logic [CW:0]  sum_d, sum_b, sum_t;

   logic [3:0]         status_in;
   logic signed [4:0]  rp_in;
   logic signed [6:0]  rl_in;
   logic               conv_in;
   logic [5:0]         oet_in, oed_in, oeb_in;

   always_comb begin
      req_masked            = req_entry;
      req_masked.start_time = req_entry.start_time & TMASK;
      req_masked.stop_time  = req_entry.stop_time & TMASK;
   end

   always_comb begin
      ns = signed'({2'b00, req_ff.start_time});
      np = signed'({2'b00, req_ff.stop_time});
      gs = signed'({18'd0, guard_ff});
      for (int i = 0; i < D; i++) begin
         s0[i] = signed'({2'b00, tbl_ff[i].start_time}) - gs;
         s1[i] = signed'({2'b00, tbl_ff[i].stop_time}) + gs;
         route_hit[i] = valid_ff[i] && tbl_ff[i].in_port == req_ff.in_port
                        && tbl_ff[i].in_lambda == req_ff.in_lambda
                        && !(tbl_ff[i].is_buffer && !tbl_ff[i].to_buffer);
         id_hit[i] = valid_ff[i] && tbl_ff[i].entry_id == req_ff.entry_id;
         clash_hit[i] = valid_ff[i] && !(tbl_ff[i].is_buffer && tbl_ff[i].to_buffer)
                        && tbl_ff[i].out_port == req_ff.out_port
                        && tbl_ff[i].out_lambda == req_ff.out_lambda
                        && !((s0[i] > ns && s0[i] >= np) || (s1[i] <= ns && s1[i] < np));
         wr_slot[i] = !valid_ff[i] && (i == 0 || valid_ff[(i == 0) ? 0 : i - 1]);
      end
      route_first = route_hit & (~route_hit + 1'b1);
      id_first    = id_hit & (~id_hit + 1'b1);
      id_ge       = ~(id_first - 1'b1);
      route_sel = '0;
      id_sel    = '0;
      for (int i = 0; i < D; i++) begin
         if (route_first[i]) route_sel = route_sel | tbl_ff[i];
         if (id_first[i])    id_sel    = id_sel | tbl_ff[i];
      end
      clash = !req_ff.is_buffer && !req_ff.is_disagg && (|clash_hit);
      full  = valid_ff[D-1];
   end

   always_comb begin
      tbl_in    = tbl_ff;
      valid_in  = valid_ff;
      cnt_d_in  = cnt_d_ff;
      cnt_b_in  = cnt_b_ff;
      status_in = ST_DROPPED;
      rp_in     = '1;
      rl_in     = '1;
      conv_in   = 1'b0;
      oet_in    = '0;
      oed_in    = '0;
      oeb_in    = '0;
      sum_d     = '0;
      sum_b     = '0;
      sum_t     = '0;
      unique case (mode_type'(mode_ff))
         MODE_ROUTE: begin
            if (|route_hit) begin
               if (route_sel.is_disagg) begin
                  status_in = ST_DISAGG;
               end else if (!route_sel.out_port[4] && !route_sel.out_lambda[6]) begin
                  status_in = ST_SWITCHED;
                  rp_in     = route_sel.out_port;
                  rl_in     = route_sel.out_lambda;
                  conv_in   = route_sel.out_lambda != signed'({1'b0, req_ff.in_lambda});
               end
            end
         end
         MODE_INSERT: begin
            if (clash) begin
               status_in = ST_CONFLICT;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_INSERTED;
               for (int i = 0; i < D; i++) begin
                  if (wr_slot[i]) tbl_in[i] = req_ff;
               end
               valid_in = {valid_ff[D-2:0], 1'b1};
               cnt_d_in = cnt_d_ff + CW'(req_ff.is_disagg);
               cnt_b_in = cnt_b_ff + CW'(req_ff.is_buffer & req_ff.to_buffer);
               conv_in  = !req_ff.is_buffer
                          && signed'({1'b0, req_ff.in_lambda}) != req_ff.out_lambda;
               sum_d  = {1'b0, cnt_d_in};
               sum_b  = {1'b0, cnt_b_in};
               sum_t  = sum_d + sum_b;
               oed_in = 6'(sum_d);
               oeb_in = 6'(sum_b);
               oet_in = 6'(sum_t);
            end
         end
         MODE_REMOVE: begin
            if (|id_hit) begin
               status_in = ST_REMOVED;
               for (int i = 0; i < D - 1; i++) begin
                  if (id_ge[i]) tbl_in[i] = tbl_ff[i+1];
               end
               valid_in = {1'b0, valid_ff[D-1:1]};
               cnt_d_in = cnt_d_ff - CW'(id_sel.is_disagg);
               cnt_b_in = cnt_b_ff - CW'(id_sel.is_buffer & id_sel.to_buffer);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         MODE_VERIFY: status_in = (|id_hit) ? ST_VERIFIED : ST_UNKNOWN;
         default: status_in = ST_DROPPED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_d_ff <= '0;
         cnt_b_ff <= '0;
         guard_ff <= '0;
      end else begin
         if (csr_we) guard_ff <= csr_wdata;
         if (cmd.commit) begin
            valid_ff <= valid_in;
            cnt_d_ff <= cnt_d_in;
            cnt_b_ff <= cnt_b_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         req_ff  <= req_masked;
      end
      if (cmd.commit) begin
         tbl_ff           <= tbl_in;
         rsp_status       <= status_in;
         rsp_route_port   <= rp_in;
         rsp_route_lambda <= rl_in;
         rsp_converted    <= conv_in;
         rsp_elec_total   <= oet_in;
         rsp_elec_disagg  <= oed_in;
         rsp_elec_buffer  <= oeb_in;
      end
   end

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_ff & (valid_ff + 1'b1)) == '0) else $error("Valid entries not a prefix.");
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(valid_ff)) else $error("Table changed outside commit.");
   a_counts: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cnt_d_ff} <= ($countones(valid_ff)))
      && ({1'b0, cnt_b_ff} <= ($countones(valid_ff))))
      else $error("Counter exceeds entry count.");

endmodule
`default_nettype wire

// ===== hdl/optical_switch_table_with_slot_check.sv =====
// Top level of the optical switch table with slot check on insert.
// Instantiates osw_ctrl and osw_datapath; depends on osw_pkg.
//
// Usage: drive the req_ ports and raise start while busy is low; that word is
// accepted at the clock edge. Modes are route burst, insert entry, remove by
// identifier and verify identifier. One result word follows for every request:
// it appears on the rsp_ ports at the clock edge after the accepting one, stays
// for exactly one cycle with rsp_strobe high and is taken at the next edge.
// The receiver cannot stall. The block takes no new word while busy: first the
// request is captured, then the match, slot check and update of all
// TABLE_DEPTH entries are done in parallel. A new word may be accepted in the
// cycle the result is shown.
// The guard time register is written through csr_we and csr_wdata; the user
// must write it only while the block is idle. The block itself does not
// enforce this. Synchronous reset empties the table, clears the counters and
// the guard time.
`default_nettype none
module optical_switch_table_with_slot_check #(
   parameter int TABLE_DEPTH = 32,
   parameter int TIME_BITS   = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic [3:0]         req_in_port,
   input  wire logic [5:0]         req_in_lambda,
   input  wire logic signed [4:0]  req_out_port,
   input  wire logic signed [6:0]  req_out_lambda,
   input  wire logic               req_is_buffer,
   input  wire logic               req_to_buffer,
   input  wire logic               req_is_disagg,
   input  wire logic [31:0]        req_start_time,
   input  wire logic [31:0]        req_stop_time,
   input  wire logic [15:0]        req_entry_id,
   input  wire logic               csr_we,
   input  wire logic [15:0]        csr_wdata,
   output logic                    rsp_strobe,
   output logic [3:0]              rsp_status,
   output logic signed [4:0]       rsp_route_port,
   output logic signed [6:0]       rsp_route_lambda,
   output logic                    rsp_converted,
   output logic [5:0]              rsp_elec_total,
   output logic [5:0]              rsp_elec_disagg,
   output logic [5:0]              rsp_elec_buffer
);
   import osw_pkg::*;

   cmd_type   cmd;
   entry_type req_entry;

   assign req_entry = '{in_port: req_in_port, in_lambda: req_in_lambda,
                        out_port: req_out_port, out_lambda: req_out_lambda,
                        is_buffer: req_is_buffer, to_buffer: req_to_buffer,
                        is_disagg: req_is_disagg, start_time: req_start_time,
                        stop_time: req_stop_time, entry_id: req_entry_id};

   osw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   osw_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_mode         (req_mode),
      .req_entry        (req_entry),
      .rsp_status       (rsp_status),
      .rsp_route_port   (rsp_route_port),
      .rsp_route_lambda (rsp_route_lambda),
      .rsp_converted    (rsp_converted),
      .rsp_elec_total   (rsp_elec_total),
      .rsp_elec_disagg  (rsp_elec_disagg),
      .rsp_elec_buffer  (rsp_elec_buffer)
   );

endmodule
`default_nettype wire
